// ===== rtl/avr_pkg.sv =====
package avr_pkg;

    // Sizing of the sine/cosine unit
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    // Datapath widths
    localparam int CW = 34;   // CORDIC x, y, residual (Q.30 plus headroom)
    localparam int AW = 16;   // axis component
    localparam int VW = 32;   // vector component
    localparam int EW = 31;   // matrix entry, Q.29 in [-2, 2)

    localparam logic signed [CW-1:0] GAIN_Q30  = CW'(652032874);
    localparam logic signed [CW-1:0] ONE_Q30   = CW'(64'sd1073741824);
    localparam logic signed [39:0]   ENTRY_MAX = 40'sd1073741823;
    localparam logic signed [39:0]   ENTRY_MIN = -40'sd1073741824;
    localparam logic signed [36:0]   OUT_MAX   = 37'sd2147483647;
    localparam logic signed [36:0]   OUT_MIN   = -37'sd2147483648;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [VW-1:0] vec_x;
        logic signed [VW-1:0] vec_y;
        logic signed [VW-1:0] vec_z;
        logic signed [AW-1:0] axis_x;
        logic signed [AW-1:0] axis_y;
        logic signed [AW-1:0] axis_z;
        logic [15:0]          rotation_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] out_x;
        logic signed [VW-1:0] out_y;
        logic signed [VW-1:0] out_z;
        logic                 saturated;
    } t_out_item;

    typedef logic signed [VW-1:0] t_vec [0:2];
    typedef logic signed [EW-1:0] t_mat [0:2][0:2];

endpackage

// ===== rtl/avr_cordic.sv =====
module avr_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  avr_pkg::t_in_item               i_data,
    output logic                            o_valid,
    output avr_pkg::t_in_item               o_data,
    output logic signed [avr_pkg::CW-1:0]   o_cos,
    output logic signed [avr_pkg::CW-1:0]   o_sin
);
    import avr_pkg::*;

    logic signed [CW-1:0] r_x   [0:NUM_STAGES];
    logic signed [CW-1:0] r_y   [0:NUM_STAGES];
    logic signed [CW-1:0] r_z   [0:NUM_STAGES];
    logic                 r_neg [0:NUM_STAGES];
    t_in_item             r_item[0:NUM_STAGES];
    logic                 r_v   [0:NUM_STAGES];
    logic signed [CW-1:0] r_cos, r_sin;
    t_in_item             r_oitem;
    logic                 r_ov;

    logic [31:0] n_phase_ext, n_phase;
    logic        n_neg;

    // Quadrant fold: second and third quadrants are rotated by half a turn
    always_comb begin
        n_phase_ext = 32'(i_data.rotation_angle);
        n_phase     = n_phase_ext << (32 - ANGLE_BITS);
        n_neg       = (n_phase[31:30] == 2'b01) || (n_phase[31:30] == 2'b10);
        if (n_neg) begin
            n_phase = n_phase + 32'h80000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= CW'(signed'(n_phase));
            r_neg[0]  <= n_neg;
            r_item[0] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // One micro-rotation per register stage
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        logic signed [CW-1:0] n_xs, n_ys, n_at;
        always_comb begin
            n_xs = r_x[g] >>> g;
            n_ys = r_y[g] >>> g;
            n_at = CW'(signed'({1'b0, ATAN_TURNS[g]}));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] - n_ys;
                    r_y[g+1] <= r_y[g] + n_xs;
                    r_z[g+1] <= r_z[g] - n_at;
                end else begin
                    r_x[g+1] <= r_x[g] + n_ys;
                    r_y[g+1] <= r_y[g] - n_xs;
                    r_z[g+1] <= r_z[g] + n_at;
                end
                r_neg[g+1]  <= r_neg[g];
                r_item[g+1] <= r_item[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end
    end

    // Undo the quadrant fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos   <= r_neg[NUM_STAGES] ? -r_x[NUM_STAGES] : r_x[NUM_STAGES];
            r_sin   <= r_neg[NUM_STAGES] ? -r_y[NUM_STAGES] : r_y[NUM_STAGES];
            r_oitem <= r_item[NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NUM_STAGES];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_oitem;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

// ===== rtl/avr_matrix.sv =====
module avr_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  avr_pkg::t_in_item             i_data,
    input  logic signed [avr_pkg::CW-1:0] i_cos,
    input  logic signed [avr_pkg::CW-1:0] i_sin,
    output logic                          o_valid,
    output avr_pkg::t_vec                 o_vec,
    output avr_pkg::t_mat                 o_mat
);
    import avr_pkg::*;

    logic signed [AW-1:0] n_a [0:2];
    t_vec                 n_v;

    // stage 1: axis products, t = 1 - c, c and a*s rounded to Q.29
    logic signed [31:0]   r1_aa [0:2][0:2];
    logic signed [CW-1:0] r1_t;
    logic signed [CW-1:0] r1_c29;
    logic signed [35:0]   r1_sa [0:2];
    t_vec                 r1_v;
    // stage 2: a_i*a_j*t
    logic signed [65:0]   r2_p  [0:2][0:2];
    logic signed [CW-1:0] r2_c29;
    logic signed [35:0]   r2_sa [0:2];
    t_vec                 r2_v;
    // stage 3: entries
    t_mat                 r3_m;
    t_vec                 r3_v;
    logic [2:0]           r_v;

    always_comb begin
        n_a[0] = i_data.axis_x;
        n_a[1] = i_data.axis_y;
        n_a[2] = i_data.axis_z;
        n_v[0] = i_data.vec_x;
        n_v[1] = i_data.vec_y;
        n_v[2] = i_data.vec_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_aa[r][k] <= 32'(n_a[r] * n_a[k]);
                end
                r1_sa[r] <= 36'((50'(n_a[r]) * 50'(i_sin) + 50'sd16384) >>> 15);
            end
            r1_t   <= ONE_Q30 - i_cos;
            r1_c29 <= (i_cos + CW'(1)) >>> 1;
            r1_v   <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_p[r][k] <= 66'(r1_aa[r][k]) * 66'(r1_t);
                end
            end
            r2_c29 <= r1_c29;
            r2_sa  <= r1_sa;
            r2_v   <= r1_v;
        end
    end

    // Round, add cosine on the diagonal and the sine cross terms, clamp
    logic signed [39:0] n_e [0:2][0:2];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_e[r][k] = 40'((r2_p[r][k] + 66'sd268435456) >>> 29);
                if (r == k) begin
                    n_e[r][k] = n_e[r][k] + 40'(r2_c29);
                end
            end
        end
        n_e[0][1] = n_e[0][1] - 40'(r2_sa[2]);
        n_e[0][2] = n_e[0][2] + 40'(r2_sa[1]);
        n_e[1][0] = n_e[1][0] + 40'(r2_sa[2]);
        n_e[1][2] = n_e[1][2] - 40'(r2_sa[0]);
        n_e[2][0] = n_e[2][0] - 40'(r2_sa[1]);
        n_e[2][1] = n_e[2][1] + 40'(r2_sa[0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    if (n_e[r][k] > ENTRY_MAX) begin
                        r3_m[r][k] <= EW'(ENTRY_MAX);
                    end else if (n_e[r][k] < ENTRY_MIN) begin
                        r3_m[r][k] <= EW'(ENTRY_MIN);
                    end else begin
                        r3_m[r][k] <= EW'(n_e[r][k]);
                    end
                end
            end
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_vec   = r3_v;
    assign o_mat   = r3_m;

endmodule

// ===== rtl/avr_mvmul.sv =====
module avr_mvmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  avr_pkg::t_vec     i_vec,
    input  avr_pkg::t_mat     i_mat,
    output logic              o_valid,
    output avr_pkg::t_out_item o_data
);
    import avr_pkg::*;

    logic signed [62:0] r1_p   [0:2][0:2];
    logic signed [36:0] r2_acc [0:2];
    t_out_item          r3_out;
    logic [2:0]         r_v;
    logic signed [VW-1:0] n_o  [0:2];
    logic                 n_sat;

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_p[r][k] <= 63'(i_vec[k]) * 63'(i_mat[r][k]);
                end
            end
        end
    end

    // stage 2: row sums, rounded back to Q16.16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r2_acc[r] <= 37'((66'(r1_p[r][0]) + 66'(r1_p[r][1]) + 66'(r1_p[r][2])
                                  + 66'sd268435456) >>> 29);
            end
        end
    end

    // stage 3: clamp to 32 bits
    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            if (r2_acc[r] > OUT_MAX) begin
                n_o[r] = VW'(OUT_MAX);
                n_sat  = 1'b1;
            end else if (r2_acc[r] < OUT_MIN) begin
                n_o[r] = VW'(OUT_MIN);
                n_sat  = 1'b1;
            end else begin
                n_o[r] = VW'(r2_acc[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_out.out_x     <= n_o[0];
            r3_out.out_y     <= n_o[1];
            r3_out.out_z     <= n_o[2];
            r3_out.saturated <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r3_out;

endmodule

// ===== rtl/axis_angle_vector_rotate.sv =====
// Axis-angle vector rotation.
// Input channel: i_valid / o_stall with i_data (vector Q16.16, unit axis Q1.14,
// angle as a fraction of a turn). An item is taken at a clock edge where
// i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_data (rotated vector Q16.16,
// saturated flag). An item leaves at an edge where o_valid is high and
// i_stall is low.
// Register stages: sine/cosine pipeline (CORDIC_STAGES + 2), matrix build
// (3), matrix-vector product (3). Throughput is one item per cycle while
// the output is not stalled; every stage is a register and no unit is
// shared.
// The whole pipeline advances on one enable. When the receiver stalls while
// an item waits at the output, every stage holds and o_stall is raised; in
// all other cycles the block takes a new item.
// Reset (i_rst_n low, synchronous) clears all valid bits; no item in flight
// survives it.
module axis_angle_vector_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  avr_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output avr_pkg::t_out_item o_data
);
    import avr_pkg::*;

    logic                 en;
    logic                 cv, mv;
    t_in_item             c_item;
    logic signed [CW-1:0] c_cos, c_sin;
    t_vec                 m_vec;
    t_mat                 m_mat;

    // Pipeline moves unless the output item is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    avr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (cv),
        .o_data  (c_item),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    avr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cv),
        .i_data  (c_item),
        .i_cos   (c_cos),
        .i_sin   (c_sin),
        .o_valid (mv),
        .o_vec   (m_vec),
        .o_mat   (m_mat)
    );

    avr_mvmul u_mvmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mv),
        .i_vec   (m_vec),
        .i_mat   (m_mat),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // Stall toward the sender only comes from a held output item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output item");

    // Flag implies a clamped component
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.saturated) |->
            (o_data.out_x == 32'sh7FFFFFFF || o_data.out_x == 32'sh80000000 ||
             o_data.out_y == 32'sh7FFFFFFF || o_data.out_y == 32'sh80000000 ||
             o_data.out_z == 32'sh7FFFFFFF || o_data.out_z == 32'sh80000000))
        else $error("saturated set without a clamped component");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ===== tb/axis_angle_vector_rotate_test.sv =====
`timescale 1ns / 100ps

module axis_angle_vector_rotate_test;
    import avr_pkg::*;

    localparam int LATENCY = CORDIC_STAGES + 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    axis_angle_vector_rotate u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // atan(2^-i) in turns, 2^32 per turn
    localparam logic [31:0] ATAN_LUT [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    t_in_item  pending_items[$];
    t_out_item rotated_expect[$];
    int        mismatch_count = 0;
    bit        hold_rx = 0;      // long receiver hold-off request
    bit        hold_tx = 0;      // sender pause request
    int        hold_rx_left = 0;

    // Clock
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_q29(longint v);
        if (v > 64'sd1073741823) return 64'sd1073741823;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // Predicted rotated vector for one item
    function automatic t_out_item rotate_vector(t_in_item it);
        t_out_item   res;
        longint      v[3], a[3], m[9], sa[3];
        longint      cx, sy, nx, z, t, c29, acc;
        logic [31:0] phase;
        bit          flip;
        bit          sat;
        v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
        a[0] = it.axis_x; a[1] = it.axis_y; a[2] = it.axis_z;
        phase = 32'(it.rotation_angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip) phase = phase + 32'h80000000;
        z = longint'($signed(phase));
        cx = 652032874;
        sy = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = cx - (sy >>> i);
                sy = sy + (cx >>> i);
                z = z - longint'(ATAN_LUT[i]);
            end else begin
                nx = cx + (sy >>> i);
                sy = sy - (cx >>> i);
                z = z + longint'(ATAN_LUT[i]);
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        t = (longint'(1) <<< 30) - cx;
        c29 = round_shift(cx, 1);
        for (int k = 0; k < 3; k++) sa[k] = round_shift(a[k] * sy, 15);
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                m[r*3+k] = round_shift(a[r] * a[k] * t, 29) + ((r == k) ? c29 : 0);
        m[1] -= sa[2]; m[2] += sa[1];
        m[3] += sa[2]; m[5] -= sa[0];
        m[6] -= sa[1]; m[7] += sa[0];
        for (int k = 0; k < 9; k++) m[k] = clamp_q29(m[k]);
        sat = 0;
        for (int r = 0; r < 3; r++) begin
            acc = round_shift(v[0]*m[r*3] + v[1]*m[r*3+1] + v[2]*m[r*3+2], 29);
            if (acc > 64'sd2147483647) begin acc = 64'sd2147483647; sat = 1; end
            if (acc < -64'sd2147483648) begin acc = -64'sd2147483648; sat = 1; end
            if (r == 0) res.out_x = acc[31:0];
            else if (r == 1) res.out_y = acc[31:0];
            else res.out_z = acc[31:0];
        end
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 1 << 20))) - (1 <<< 19);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    // Queue one item for the driver
    task automatic push_item(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [15:0] ax,
                             logic signed [15:0] ay, logic signed [15:0] az,
                             logic [15:0] ang);
        t_in_item it;
        it.vec_x = x; it.vec_y = y; it.vec_z = z;
        it.axis_x = ax; it.axis_y = ay; it.axis_z = az;
        it.rotation_angle = ang;
        pending_items.push_back(it);
    endtask

    // Driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            tx_gap <= 0;
        end else if (i_valid && !o_stall) begin
            // item taken this edge
            rotated_expect.push_back(rotate_vector(i_data));
            if (tx_gap == 0 && !hold_tx && pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
                tx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
            end else begin
                i_valid <= 0;
                tx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
            end
        end else if (!i_valid) begin
            if (tx_gap > 0) tx_gap <= tx_gap - 1;
            else if (!hold_tx && pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1;
            end
        end
    end

    // Receiver stall and monitor
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            rx_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (rotated_expect.size() == 0) begin
                    report_mismatch("unexpected output item", 1, 0);
                end else begin
                    t_out_item w;
                    w = rotated_expect.pop_front();
                    if (o_data.out_x !== w.out_x)
                        report_mismatch("out_x", o_data.out_x, w.out_x);
                    if (o_data.out_y !== w.out_y)
                        report_mismatch("out_y", o_data.out_y, w.out_y);
                    if (o_data.out_z !== w.out_z)
                        report_mismatch("out_z", o_data.out_z, w.out_z);
                    if (o_data.saturated !== w.saturated)
                        report_mismatch("saturated", o_data.saturated, w.saturated);
                end
            end
            if (hold_rx_left > 0) begin
                hold_rx_left <= hold_rx_left - 1;
                i_stall <= 1;
            end else if (hold_rx) begin
                hold_rx_left <= 200;
                i_stall <= 1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
                rx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
            end
        end
    end

    // Stimulus
    initial begin
        logic signed [15:0] ax, ay, az;
        int sel;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, quadrant edges, non-unit axes, high angle bits
        push_item(32'sh00010000, 0, 0, 0, 0, 16'sd16384, 16'h0000);
        push_item(32'sh00010000, 0, 0, 0, 0, 16'sd16384, 16'h4000);
        push_item(32'sh00010000, 0, 0, 0, 0, 16'sd16384, 16'h8000);
        push_item(32'sh00010000, 0, 0, 0, 0, 16'sd16384, 16'hC000);
        push_item(0, 32'sh00010000, 0, 16'sd16384, 0, 0, 16'h3FFF);
        push_item(0, 0, 32'sh00010000, 0, 16'sd16384, 0, 16'hBFFF);
        push_item(0, 0, 32'sh00010000, 0, -16'sd16384, 0, 16'h7FFF);
        push_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  16'sd9459, 16'sd9459, 16'sd9459, 16'h1555);
        push_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  -16'sd9459, -16'sd9459, -16'sd9459, 16'hFFFF);
        push_item(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h2000);
        push_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'hA000);
        push_item(32'sh12345678, -32'sh0ABCDEF0, 32'sh00000001,
                  16'sh7FFF, 16'sh8000, 16'sh0000, 16'h6000);
        push_item(32'sh7FFFFFFF, 0, 0, 0, 16'sd16384, 0, 16'h2000);
        push_item(-32'sh7FFFFFFF, 0, 0, 0, 0, 0, 16'hE000);
        push_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8001);
        push_item(0, 0, 0, 16'sd16384, 16'sd16384, 16'sd16384, 16'h4001);

        // Random, with the pressure phases midway
        for (int n = 0; n < 1050; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                // roughly unit axis along a random principal or diagonal
                case ($urandom_range(0, 3))
                    0: begin ax = 16'sd16384; ay = 0; az = 0; end
                    1: begin ax = 0; ay = -16'sd16384; az = 0; end
                    2: begin ax = 16'sd11585; ay = 0; az = -16'sd11585; end
                    default: begin ax = 16'sd9459; ay = -16'sd9459; az = 16'sd9459; end
                endcase
                push_item(rand_vec(), rand_vec(), rand_vec(), ax, ay, az, 16'($urandom));
            end else begin
                push_item(rand_vec(), rand_vec(), rand_vec(),
                          rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
            end
            if (n == 300) begin
                wait (pending_items.size() == 0);
                // sender pause until the pipeline drains
                hold_tx = 1;
                wait (rotated_expect.size() == 0 && !(i_valid));
                repeat (LATENCY + 4) @(posedge i_clk);
                hold_tx = 0;
            end
            if (n == 600) begin
                // request stays up until the receiver has started its hold
                @(posedge i_clk);
                hold_rx = 1;
                wait (hold_rx_left > 0);
                hold_rx = 0;
            end
        end
        wait (pending_items.size() == 0 && !i_valid);
        wait (rotated_expect.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Timeout
    initial begin
        #(8 * 200000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
